// ----- src/surq_pkg.sv -----
// Shared types, codes and latency tables for the shared unit request queue.
`default_nettype none

package surq_pkg;

    localparam int CPU_W   = 4;
    localparam int THR_W   = 4;
    localparam int OP_W    = 4;
    localparam int LAT_W   = 8;
    localparam int CNT_W   = 5;
    localparam int EV_W    = 3;
    localparam int KIND_W  = 2;
    localparam int CIDX_W  = 2;
    localparam int CDATA_W = 8;

    // event codes
    localparam logic [EV_W-1:0] EV_STARTED   = 3'd0;
    localparam logic [EV_W-1:0] EV_QUEUED    = 3'd1;
    localparam logic [EV_W-1:0] EV_REJECTED  = 3'd2;
    localparam logic [EV_W-1:0] EV_COMPLETED = 3'd3;
    localparam logic [EV_W-1:0] EV_DEQUEUED  = 3'd4;

    // item kinds
    localparam logic REQ_UNIT = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    // unit kinds
    localparam logic [KIND_W-1:0] KIND_TRIG   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_MATRIX = 2'd1;

    // configuration register indexes
    localparam logic [CIDX_W-1:0] CFG_UNIT_KIND   = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_DEFAULT_LAT = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_QUEUE_LIMIT = 2'd2;

    // configuration reset values
    localparam logic [KIND_W-1:0] RST_UNIT_KIND   = 2'd0;
    localparam logic [LAT_W-1:0]  RST_DEFAULT_LAT = 8'd10;
    localparam logic [CNT_W-1:0]  RST_QUEUE_LIMIT = 5'd4;

    typedef struct packed {
        logic [CPU_W-1:0] cpu;
        logic [THR_W-1:0] thread;
        logic [LAT_W-1:0] lat;
    } entry_t;

    // table hit flag in the top bit, latency below
    function automatic logic [LAT_W:0] trig_lat(input logic [OP_W-1:0] op);
        logic [LAT_W:0] r;
        begin
            case (op)
                4'd0:    r = {1'b1, 8'd15};
                4'd1:    r = {1'b1, 8'd15};
                4'd2:    r = {1'b1, 8'd20};
                4'd3:    r = {1'b1, 8'd18};
                4'd4:    r = {1'b1, 8'd22};
                4'd5:    r = {1'b1, 8'd12};
                4'd6:    r = {1'b1, 8'd18};
                default: r = '0;
            endcase
            return r;
        end
    endfunction

    function automatic logic [LAT_W:0] matrix_lat(input logic [OP_W-1:0] op);
        logic [LAT_W:0] r;
        begin
            case (op)
                4'd0:    r = {1'b1, 8'd50};
                4'd1:    r = {1'b1, 8'd9};
                4'd2:    r = {1'b1, 8'd100};
                4'd3:    r = {1'b1, 8'd27};
                4'd4:    r = {1'b1, 8'd9};
                4'd5:    r = {1'b1, 8'd9};
                default: r = '0;
            endcase
            return r;
        end
    endfunction

endpackage

`default_nettype wire

// ----- src/surq_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module surq_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  wire logic                                   clk,
    input  wire logic                                   we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                       wdata,
    input  wire logic                                   re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ----- src/surq_lat_lookup.sv -----
// Operation latency lookup from the built-in unit tables or the default latency.
`default_nettype none

module surq_lat_lookup (
    input  wire logic [surq_pkg::KIND_W-1:0] unit_kind,
    input  wire logic [surq_pkg::LAT_W-1:0]  dflt_lat,
    input  wire logic [surq_pkg::OP_W-1:0]   op_code,
    output logic      [surq_pkg::LAT_W-1:0]  lat
);

    logic [surq_pkg::LAT_W:0] trig_hit;
    logic [surq_pkg::LAT_W:0] mat_hit;

    always_comb
    begin
        trig_hit = surq_pkg::trig_lat(op_code);
        mat_hit  = surq_pkg::matrix_lat(op_code);
        lat      = dflt_lat;
        if (unit_kind == surq_pkg::KIND_TRIG && trig_hit[surq_pkg::LAT_W])
        begin
            lat = trig_hit[surq_pkg::LAT_W-1:0];
        end
        else if (unit_kind == surq_pkg::KIND_MATRIX && mat_hit[surq_pkg::LAT_W])
        begin
            lat = mat_hit[surq_pkg::LAT_W-1:0];
        end
    end

endmodule

`default_nettype wire

// ----- src/shared_unit_request_queue.sv -----
// Shared unit request queue: arbitration state, wait queue and result register.
// Results are registered: they appear in the result register in the cycle after start is taken.
// Throughput: one item per cycle while busy is low; a completion with a waiting request
// gives two beats, completion then dequeue; busy is high while the first is out (queue RAM read).
// Reset clears unit state, queue pointers and the result strobe, and loads the
// register defaults; queue storage is not cleared. The receiver cannot stall.
`default_nettype none

module shared_unit_request_queue #(
    parameter int QUEUE_DEPTH = 16
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // configuration
    input  wire logic                            cfg_we,
    input  wire logic [surq_pkg::CIDX_W-1:0]     cfg_index,
    input  wire logic [surq_pkg::CDATA_W-1:0]    cfg_data,
    // command
    input  wire logic                            start,
    output logic                                 busy,
    input  wire logic                            req_type,
    input  wire logic [surq_pkg::CPU_W-1:0]      cpu_id,
    input  wire logic [surq_pkg::THR_W-1:0]      thread_id,
    input  wire logic [surq_pkg::OP_W-1:0]       op_code,
    // results
    output logic                                 strobe,
    output logic [surq_pkg::EV_W-1:0]            event_res,
    output logic [surq_pkg::CPU_W-1:0]           who_cpu,
    output logic [surq_pkg::THR_W-1:0]           who_thread,
    output logic [surq_pkg::LAT_W-1:0]           op_latency,
    output logic [surq_pkg::CNT_W-1:0]           waiting,
    output logic                                 last
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam int ENTRY_W = $bits(surq_pkg::entry_t);

    // configuration registers
    logic [surq_pkg::KIND_W-1:0] unit_kind_reg;
    logic [surq_pkg::LAT_W-1:0]  default_lat_reg;
    logic [surq_pkg::CNT_W-1:0]  queue_limit_reg;

    // unit state
    logic                        unit_busy_reg, unit_busy_next;
    logic [surq_pkg::LAT_W-1:0]  ticks_reg, ticks_next;
    logic [surq_pkg::CPU_W-1:0]  owner_cpu_reg, owner_cpu_next;
    logic [surq_pkg::THR_W-1:0]  owner_thr_reg, owner_thr_next;
    logic [PTR_W-1:0]            head_reg, head_next;
    logic [PTR_W-1:0]            tail_reg, tail_next;
    logic [surq_pkg::CNT_W-1:0]  count_reg, count_next;
    logic                        pend_reg, pend_next;

    // result register
    logic                        strobe_reg, strobe_next;
    logic [surq_pkg::EV_W-1:0]   ev_reg, ev_next;
    logic [surq_pkg::CPU_W-1:0]  who_cpu_reg, who_cpu_next;
    logic [surq_pkg::THR_W-1:0]  who_thr_reg, who_thr_next;
    logic [surq_pkg::LAT_W-1:0]  lat_reg, lat_next;
    logic [surq_pkg::CNT_W-1:0]  wait_reg, wait_next;
    logic                        last_reg, last_next;

    logic                        accept;
    logic [surq_pkg::LAT_W-1:0]  req_lat;
    logic [surq_pkg::CNT_W-1:0]  limit;
    logic                        ram_we;
    logic                        ram_re;
    surq_pkg::entry_t            ram_wdata;
    surq_pkg::entry_t            ram_rdata;
    logic [ENTRY_W-1:0]          ram_rbits;

    assign busy   = pend_reg;
    assign accept = start && !pend_reg;

    surq_lat_lookup u_lat (
        .unit_kind (unit_kind_reg),
        .dflt_lat  (default_lat_reg),
        .op_code   (op_code),
        .lat       (req_lat)
    );

    surq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (tail_reg),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (head_reg),
        .rdata (ram_rbits)
    );

    assign ram_rdata = surq_pkg::entry_t'(ram_rbits);

    // limit saturates at the queue depth
    always_comb
    begin
        if (32'(queue_limit_reg) > 32'(QUEUE_DEPTH))
        begin
            limit = surq_pkg::CNT_W'(QUEUE_DEPTH);
        end
        else
        begin
            limit = queue_limit_reg;
        end
    end

    always_comb
    begin
        unit_busy_next = unit_busy_reg;
        ticks_next     = ticks_reg;
        owner_cpu_next = owner_cpu_reg;
        owner_thr_next = owner_thr_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        count_next     = count_reg;
        pend_next      = 1'b0;

        strobe_next    = 1'b0;
        ev_next        = ev_reg;
        who_cpu_next   = who_cpu_reg;
        who_thr_next   = who_thr_reg;
        lat_next       = lat_reg;
        wait_next      = wait_reg;
        last_next      = last_reg;

        ram_we         = 1'b0;
        ram_re         = 1'b0;
        ram_wdata      = '{cpu: cpu_id, thread: thread_id, lat: req_lat};

        if (pend_reg)
        begin
            // head entry has been read; start it
            unit_busy_next = 1'b1;
            owner_cpu_next = ram_rdata.cpu;
            owner_thr_next = ram_rdata.thread;
            ticks_next     = ram_rdata.lat;
            head_next      = (head_reg == PTR_LAST) ? '0 : head_reg + 1'b1;
            count_next     = count_reg - 1'b1;
            strobe_next    = 1'b1;
            ev_next        = surq_pkg::EV_DEQUEUED;
            who_cpu_next   = ram_rdata.cpu;
            who_thr_next   = ram_rdata.thread;
            lat_next       = ram_rdata.lat;
            wait_next      = count_reg - 1'b1;
            last_next      = 1'b1;
        end
        else if (accept)
        begin
            if (req_type == surq_pkg::REQ_UNIT)
            begin
                strobe_next  = 1'b1;
                who_cpu_next = cpu_id;
                who_thr_next = thread_id;
                last_next    = 1'b1;
                if (!unit_busy_reg)
                begin
                    unit_busy_next = 1'b1;
                    owner_cpu_next = cpu_id;
                    owner_thr_next = thread_id;
                    ticks_next     = req_lat;
                    ev_next        = surq_pkg::EV_STARTED;
                    lat_next       = req_lat;
                    wait_next      = count_reg;
                end
                else if (count_reg < limit)
                begin
                    ram_we     = 1'b1;
                    tail_next  = (tail_reg == PTR_LAST) ? '0 : tail_reg + 1'b1;
                    count_next = count_reg + 1'b1;
                    ev_next    = surq_pkg::EV_QUEUED;
                    lat_next   = req_lat;
                    wait_next  = count_reg + 1'b1;
                end
                else
                begin
                    ev_next   = surq_pkg::EV_REJECTED;
                    lat_next  = '0;
                    wait_next = count_reg;
                end
            end
            else if (unit_busy_reg)
            begin
                if (ticks_reg > surq_pkg::LAT_W'(1))
                begin
                    ticks_next = ticks_reg - 1'b1;
                end
                else
                begin
                    strobe_next    = 1'b1;
                    ev_next        = surq_pkg::EV_COMPLETED;
                    who_cpu_next   = owner_cpu_reg;
                    who_thr_next   = owner_thr_reg;
                    lat_next       = '0;
                    wait_next      = count_reg;
                    owner_cpu_next = '0;
                    owner_thr_next = '0;
                    ticks_next     = '0;
                    if (count_reg == '0)
                    begin
                        unit_busy_next = 1'b0;
                        last_next      = 1'b1;
                    end
                    else
                    begin
                        // fetch the oldest waiting request for next cycle
                        last_next = 1'b0;
                        ram_re    = 1'b1;
                        pend_next = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unit_kind_reg   <= surq_pkg::RST_UNIT_KIND;
            default_lat_reg <= surq_pkg::RST_DEFAULT_LAT;
            queue_limit_reg <= surq_pkg::RST_QUEUE_LIMIT;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                surq_pkg::CFG_UNIT_KIND:
                begin
                    unit_kind_reg <= cfg_data[surq_pkg::KIND_W-1:0];
                end
                surq_pkg::CFG_DEFAULT_LAT:
                begin
                    default_lat_reg <= cfg_data[surq_pkg::LAT_W-1:0];
                end
                surq_pkg::CFG_QUEUE_LIMIT:
                begin
                    queue_limit_reg <= cfg_data[surq_pkg::CNT_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unit_busy_reg <= 1'b0;
            ticks_reg     <= '0;
            owner_cpu_reg <= '0;
            owner_thr_reg <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            pend_reg      <= 1'b0;
            strobe_reg    <= 1'b0;
        end
        else
        begin
            unit_busy_reg <= unit_busy_next;
            ticks_reg     <= ticks_next;
            owner_cpu_reg <= owner_cpu_next;
            owner_thr_reg <= owner_thr_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            pend_reg      <= pend_next;
            strobe_reg    <= strobe_next;
        end
    end

    // result beat payload
    always_ff @(posedge clk)
    begin
        ev_reg      <= ev_next;
        who_cpu_reg <= who_cpu_next;
        who_thr_reg <= who_thr_next;
        lat_reg     <= lat_next;
        wait_reg    <= wait_next;
        last_reg    <= last_next;
    end

    assign strobe     = strobe_reg;
    assign event_res  = ev_reg;
    assign who_cpu    = who_cpu_reg;
    assign who_thread = who_thr_reg;
    assign op_latency = lat_reg;
    assign waiting    = wait_reg;
    assign last       = last_reg;

endmodule

`default_nettype wire
